// ===== sv/rxcb_pkg.sv =====
package rxcb_pkg;

   localparam int MAX_VARS = 64;
   localparam int IDX_W    = $clog2(MAX_VARS);
   localparam int CNT_W    = 16;
   localparam int VAR_W    = 7;
   localparam int T_W      = 5;
   localparam int HIDX_W   = 16;
   localparam int PROD_W   = HIDX_W + T_W;
   localparam int BIT_W    = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RV,
      ST_CV,
      ST_SCAN,
      ST_MOD,
      ST_ERD,
      ST_EOUT
   } state_type;

   // constraint size: max(1, floor(3n/10)), floor(x/10) == (x*205)>>11 for x < 1029
   function automatic logic [T_W-1:0] calc_t(input logic [VAR_W-1:0] n);
      logic [15:0] prod;
      logic [T_W-1:0] t;
      prod = 16'(({1'b0, n} + {n, 1'b0}) * 16'd205);
      t = prod[15:11];
      if (t == '0) begin
         t = T_W'(1);
      end
      return t;
   endfunction

endpackage

// ===== sv/ranked_xor_constraint_builder_top.sv =====
// Ranked XOR constraint builder. A load (mode 0) writes the next variable's
// occurrence count. A query (mode 1) ranks all n variables by scanning the
// count memory once per variable, one read per cycle, then takes the modulo
// of hash_index*T by n bit by bit, then emits its T results on consecutive
// cycles. busy stays high while a query is at work. Results are strobed by
// rsp_valid for one cycle each and cannot be held off by the receiver;
// rsp_last marks the final one.
module ranked_xor_constraint_builder_top
   import rxcb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_mode,
   input  logic [CNT_W-1:0]    req_occurrence,
   input  logic [HIDX_W-1:0]   req_hash_index,
   output logic                rsp_valid,
   output logic [VAR_W-1:0]    rsp_variable,
   output logic                rsp_rhs,
   output logic                rsp_last,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam logic [2:0] ADDR_VAR_COUNT = 3'd0;

   state_type state_ff, state_in;
   logic [VAR_W-1:0]  var_count_ff;
   logic [VAR_W-1:0]  n_eff;
   logic [T_W-1:0]    t_size;
   logic [VAR_W-1:0]  load_pos_ff, load_pos_in;
   logic [IDX_W-1:0]  v_ff, v_in;
   logic [IDX_W-1:0]  u_ff, u_in;
   logic [IDX_W-1:0]  rank_ff, rank_in;
   logic [CNT_W-1:0]  cv_ff, cv_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [VAR_W-1:0]  rem_ff, rem_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [T_W-1:0]    j_ff, j_in;
   logic              rhs_ff, rhs_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VAR_W-1:0]  rsp_variable_ff, rsp_variable_in;
   logic              rsp_rhs_ff, rsp_rhs_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]  count_mem [MAX_VARS];
   logic [CNT_W-1:0]  count_rdata_ff;
   logic [IDX_W-1:0]  count_raddr;
   logic              count_we;
   logic [IDX_W-1:0]  count_waddr;

   logic [VAR_W-1:0]  ranked_mem [MAX_VARS];
   logic [VAR_W-1:0]  ranked_rdata_ff;
   logic [IDX_W-1:0]  ranked_raddr;
   logic              ranked_we;
   logic [IDX_W-1:0]  ranked_waddr;
   logic [VAR_W-1:0]  ranked_wdata;

   logic              accept;
   logic              ahead;
   logic [VAR_W:0]    rem_shift;
   logic [VAR_W-1:0]  rem_next;
   logic [VAR_W-1:0]  load_pos_use;
   logic [VAR_W-1:0]  load_pos_inc;
   logic [VAR_W-1:0]  idx_inc;

   // effective variable count and constraint size
   always_comb begin
      if (var_count_ff == '0) begin
         n_eff = VAR_W'(1);
      end else if (var_count_ff > VAR_W'(MAX_VARS)) begin
         n_eff = VAR_W'(MAX_VARS);
      end else begin
         n_eff = var_count_ff;
      end
      t_size = calc_t(n_eff);
   end

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_VAR_COUNT) ? {25'd0, var_count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         var_count_ff <= VAR_W'(MAX_VARS);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_VAR_COUNT) begin
         var_count_ff <= csr_pwdata[VAR_W-1:0];
      end
   end

   // count memory
   always_ff @(posedge clock) begin
      if (count_we) begin
         count_mem[count_waddr] <= req_occurrence;
      end
      count_rdata_ff <= count_mem[count_raddr];
   end

   // ranking memory
   always_ff @(posedge clock) begin
      if (ranked_we) begin
         ranked_mem[ranked_waddr] <= ranked_wdata;
      end
      ranked_rdata_ff <= ranked_mem[ranked_raddr];
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // variable u ranks ahead of variable v
   assign ahead = (count_rdata_ff > cv_ff) || (count_rdata_ff == cv_ff && u_ff > v_ff);

   // restoring remainder step
   assign rem_shift = {rem_ff, prod_ff[PROD_W-1]};
   assign rem_next  = (rem_shift >= {1'b0, n_eff}) ? VAR_W'(rem_shift - {1'b0, n_eff})
                                                 : rem_shift[VAR_W-1:0];

   assign load_pos_use = (load_pos_ff >= n_eff) ? '0 : load_pos_ff;
   assign load_pos_inc = load_pos_use + VAR_W'(1);
   assign idx_inc      = {1'b0, idx_ff} + VAR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff            <= v_in;
      u_ff            <= u_in;
      rank_ff         <= rank_in;
      cv_ff           <= cv_in;
      prod_ff         <= prod_in;
      rem_ff          <= rem_in;
      bit_ff          <= bit_in;
      idx_ff          <= idx_in;
      j_ff            <= j_in;
      rhs_ff          <= rhs_in;
      rsp_variable_ff <= rsp_variable_in;
      rsp_rhs_ff      <= rsp_rhs_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      load_pos_in     = load_pos_ff;
      v_in            = v_ff;
      u_in            = u_ff;
      rank_in         = rank_ff;
      cv_in           = cv_ff;
      prod_in         = prod_ff;
      rem_in          = rem_ff;
      bit_in          = bit_ff;
      idx_in          = idx_ff;
      j_in            = j_ff;
      rhs_in          = rhs_ff;
      rsp_valid_in    = 1'b0;
      rsp_variable_in = rsp_variable_ff;
      rsp_rhs_in      = rsp_rhs_ff;
      rsp_last_in     = rsp_last_ff;
      count_we        = 1'b0;
      count_waddr     = load_pos_use[IDX_W-1:0];
      count_raddr     = v_ff;
      ranked_we       = 1'b0;
      ranked_waddr    = rank_ff;
      ranked_wdata    = {1'b0, v_ff} + VAR_W'(1);
      ranked_raddr    = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_mode) begin
                  count_we    = 1'b1;
                  load_pos_in = (load_pos_inc >= n_eff) ? '0 : load_pos_inc;
               end else begin
                  rhs_in   = ~req_hash_index[0];
                  prod_in  = PROD_W'(req_hash_index) * PROD_W'(t_size);
                  rem_in   = '0;
                  bit_in   = '0;
                  v_in     = '0;
                  state_in = ST_RV;
               end
            end
         end
         ST_RV: begin
            count_raddr = v_ff;
            state_in    = ST_CV;
         end
         ST_CV: begin
            cv_in       = count_rdata_ff;
            count_raddr = '0;
            u_in        = '0;
            rank_in     = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            rank_in     = rank_ff + IDX_W'(ahead);
            u_in        = u_ff + IDX_W'(1);
            count_raddr = u_ff + IDX_W'(1);
            if ({1'b0, u_ff} == n_eff - VAR_W'(1)) begin
               // place v at its rank
               ranked_we    = 1'b1;
               ranked_waddr = rank_ff + IDX_W'(ahead);
               if ({1'b0, v_ff} == n_eff - VAR_W'(1)) begin
                  state_in = ST_MOD;
               end else begin
                  v_in     = v_ff + IDX_W'(1);
                  state_in = ST_RV;
               end
            end
         end
         ST_MOD: begin
            rem_in  = rem_next;
            prod_in = {prod_ff[PROD_W-2:0], 1'b0};
            bit_in  = bit_ff + BIT_W'(1);
            if (bit_ff == BIT_W'(PROD_W - 1)) begin
               idx_in   = rem_next[IDX_W-1:0];
               state_in = ST_ERD;
            end
         end
         ST_ERD: begin
            ranked_raddr = idx_ff;
            idx_in       = (idx_inc == n_eff) ? '0 : idx_inc[IDX_W-1:0];
            j_in         = '0;
            state_in     = ST_EOUT;
         end
         ST_EOUT: begin
            rsp_valid_in    = 1'b1;
            rsp_variable_in = ranked_rdata_ff;
            rsp_rhs_in      = rhs_ff;
            rsp_last_in     = (j_ff == t_size - T_W'(1));
            ranked_raddr    = idx_ff;
            idx_in          = (idx_inc == n_eff) ? '0 : idx_inc[IDX_W-1:0];
            j_in            = j_ff + T_W'(1);
            if (j_ff == t_size - T_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_variable = rsp_variable_ff;
   assign rsp_rhs      = rsp_rhs_ff;
   assign rsp_last     = rsp_last_ff;

endmodule
